// ===== hdl/tast_pkg.sv =====
package tast_pkg;

	localparam int THR_W  = 32;
	localparam int HIST_W = 8;

	typedef logic [THR_W-1:0]  thr_t;
	typedef logic [HIST_W-1:0] hist_t;
	typedef logic [1:0]        sev_t;

	// severity codes, lower is worse
	localparam sev_t SEV_CRITICAL = 2'd0;
	localparam sev_t SEV_ERROR    = 2'd1;
	localparam sev_t SEV_WARNING  = 2'd2;
	localparam sev_t SEV_INFO     = 2'd3;

	typedef enum logic [1:0] {
		ST_UNKNOWN = 2'd0,
		ST_UP      = 2'd1,
		ST_DOWN    = 2'd2
	} dev_state_t;

	// direction_mode codes; the unused code behaves as rising
	localparam logic [1:0] DIR_FALLING = 2'd0;
	localparam logic [1:0] DIR_RISING  = 2'd1;
	localparam logic [1:0] DIR_AUTO    = 2'd2;

	// config register indexes
	localparam logic [1:0] REG_WARN  = 2'd0;
	localparam logic [1:0] REG_ERROR = 2'd1;
	localparam logic [1:0] REG_CRIT  = 2'd2;
	localparam logic [1:0] REG_DIR   = 2'd3;

	localparam hist_t HIST_RESET = 8'hff;

	typedef struct packed {
		thr_t       warn;
		thr_t       err;
		thr_t       crit;
		logic [1:0] dir;
	} cfg_t;

	typedef struct packed {
		logic up;
		thr_t thr;
		sev_t max_sev;
	} class_t;

	typedef struct packed {
		logic       up;
		thr_t       thr;
		sev_t       max_sev;
		sev_t       cur_sev;
		logic       log_now;
		sev_t       log_level;
		dev_state_t state;
		hist_t      hist;
	} result_t;

endpackage

// ===== hdl/tast_classify.sv =====
module tast_classify
	import tast_pkg::*;
(
	input  cfg_t   cfg,
	input  thr_t   sample,
	output class_t cls
);

	function automatic logic crosses(input thr_t v, input thr_t t, input logic rising);
		crosses = rising ? (v >= t) : (v <= t);
	endfunction

	logic rising;
	logic hit_warn;
	logic hit_err;
	logic hit_crit;

	always_comb begin
		if (cfg.dir == DIR_AUTO) begin
			rising = (cfg.crit >= cfg.warn);
		end else begin
			rising = (cfg.dir != DIR_FALLING);
		end
	end

	assign hit_warn = crosses(sample, cfg.warn, rising);
	assign hit_err  = crosses(sample, cfg.err,  rising);
	assign hit_crit = crosses(sample, cfg.crit, rising);

	// priority: critical, then error, then warning
	always_comb begin
		cls.up = ~hit_warn;
		if (hit_crit) begin
			cls.thr     = cfg.crit;
			cls.max_sev = SEV_CRITICAL;
		end else if (hit_err) begin
			cls.thr     = cfg.err;
			cls.max_sev = SEV_ERROR;
		end else if (hit_warn) begin
			cls.thr     = cfg.warn;
			cls.max_sev = SEV_WARNING;
		end else begin
			cls.thr     = cfg.warn;
			cls.max_sev = SEV_INFO;
		end
	end

endmodule

// ===== hdl/tast_track.sv =====
module tast_track
	import tast_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  class_t  cls,
	output result_t res_s2
);

	sev_t       severity_q;
	dev_state_t state_q;
	hist_t      hist_q;

	sev_t       sev_d;
	dev_state_t state_d;
	hist_t      hist_d;
	logic       log_now;
	sev_t       log_lvl;

	always_comb begin
		sev_d   = severity_q;
		state_d = state_q;
		log_now = 1'b0;
		log_lvl = SEV_INFO;
		if (cls.up) begin
			if (state_q != ST_UP) begin
				state_d = ST_UP;
				log_lvl = severity_q;
				log_now = 1'b1;
				sev_d   = SEV_INFO;
			end
			hist_d = {1'b1, hist_q[HIST_W-1:1]};
		end else begin
			// step one level toward a worse ceiling, straight to a better one
			sev_d = (severity_q > cls.max_sev) ? (severity_q - 2'd1) : cls.max_sev;
			if (sev_d != severity_q) begin
				state_d = ST_DOWN;
				log_lvl = (sev_d < severity_q) ? sev_d : severity_q;
				log_now = 1'b1;
			end
			hist_d = {1'b0, hist_q[HIST_W-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			severity_q <= SEV_INFO;
			state_q    <= ST_UNKNOWN;
			hist_q     <= HIST_RESET;
		end else if (load) begin
			severity_q <= sev_d;
			state_q    <= state_d;
			hist_q     <= hist_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2.up        <= cls.up;
			res_s2.thr       <= cls.thr;
			res_s2.max_sev   <= cls.max_sev;
			res_s2.cur_sev   <= sev_d;
			res_s2.log_now   <= log_now;
			res_s2.log_level <= log_lvl;
			res_s2.state     <= state_d;
			res_s2.hist      <= hist_d;
		end
	end

endmodule

// ===== hdl/threshold_alarm_severity_tracker.sv =====
// Threshold alarm severity tracker.
// Input channel (in_valid/in_ready) carries one sample word; output channel
// (out_valid/out_ready) returns one result word per sample, in order.
// Config is a plain write port (cfg_we, cfg_index, cfg_wdata), no wait, no
// read-back: 0 warn, 1 error, 2 critical threshold, 3 direction mode.
// Write config only while the block is empty.
// A sample is held in the input register, then moves into the result register.
// Throughput: one word per cycle while out_ready stays high, set by the single
// compare/update stage between the input register and the result register.
// Stall: the result register holds while out_ready is low; one more sample
// can sit in the input register, after which in_ready drops.
// Reset (arst_n low): thresholds 0, automatic direction, severity info,
// device state unknown, history 0xff, both stages empty.
module threshold_alarm_severity_tracker
	import tast_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] sample_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        device_up,
	output logic [31:0] crossed_threshold,
	output logic [1:0]  max_severity,
	output logic [1:0]  current_severity,
	output logic        log_now,
	output logic [1:0]  log_level,
	output logic [1:0]  up_down_state,
	output logic [7:0]  history_rating
);

	cfg_t    cfg_q;
	thr_t    sample_s1;
	logic    valid_s1;
	logic    out_valid_q;
	logic    advance;
	class_t  cls;
	result_t res_s2;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.warn <= '0;
			cfg_q.err  <= '0;
			cfg_q.crit <= '0;
			cfg_q.dir  <= DIR_AUTO;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WARN:  cfg_q.warn <= cfg_wdata;
				REG_ERROR: cfg_q.err  <= cfg_wdata;
				REG_CRIT:  cfg_q.crit <= cfg_wdata;
				REG_DIR:   cfg_q.dir  <= cfg_wdata[1:0];
				default:   cfg_q.dir  <= cfg_q.dir;
			endcase
		end
	end

	// stage 1 moves into the result register when that slot is free or draining
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= sample_value;
		end
	end

	tast_classify u_classify (
		.cfg    (cfg_q),
		.sample (sample_s1),
		.cls    (cls)
	);

	// severity/state/history live here, updated once per word
	tast_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.cls    (cls),
		.res_s2 (res_s2)
	);

	assign out_valid         = out_valid_q;
	assign device_up         = res_s2.up;
	assign crossed_threshold = res_s2.thr;
	assign max_severity      = res_s2.max_sev;
	assign current_severity  = res_s2.cur_sev;
	assign log_now           = res_s2.log_now;
	assign log_level         = res_s2.log_level;
	assign up_down_state     = res_s2.state;
	assign history_rating    = res_s2.hist;

`ifndef SYNTHESIS
	// an up word shifts a one into the newest history bit
	a_hist_up: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cls.up |=> history_rating[HIST_W-1] && out_valid)
		else $error("history did not record up status");

	// while up, stored severity is always info
	a_up_info: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && device_up |-> current_severity == SEV_INFO)
		else $error("severity not info on up word");

	// a down event logs at the worse of old and new severity
	a_down_lvl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && log_now && !device_up |-> log_level <= current_severity)
		else $error("down log level above new severity");

	// full pipe with stalled receiver must back-pressure the sender
	a_backpress: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid && !out_ready |-> !in_ready)
		else $error("input accepted with both stages full");
`endif

endmodule

// ===== verif/tb_threshold_alarm_severity_tracker.sv =====
module tb_threshold_alarm_severity_tracker;
	import tast_pkg::*;

	// Spare direction code, tracked as rising.
	localparam logic [1:0] DIR_SPARE = 2'd3;
	localparam int         N_RAND    = 660;
	localparam int         N_ROWS    = 40;

	typedef enum logic {
		ROW_CFG,
		ROW_WORD
	} row_kind_t;

	// One step of the directed sequence: a register write or a sample word.
	// Rows with hard = 1 carry a result worked out by hand; other word
	// rows take their expectation from the tracker mirror below.
	typedef struct packed {
		row_kind_t  kind;
		logic [1:0] idx;    // register index, unused on word rows
		thr_t       val;
		logic       hard;
		result_t    want;
	} stim_row_t;

	localparam result_t BY_MIRROR = '0;

	localparam stim_row_t DIR_TAB [0:N_ROWS-1] = '{
		// reset: all thresholds 0, automatic -> rising, so everything is critical
		'{ROW_WORD, REG_WARN, 32'd0, 1'b1,
			'{1'b0, 32'd0, SEV_CRITICAL, SEV_WARNING, 1'b1, SEV_WARNING, ST_DOWN, 8'h7f}},
		'{ROW_WORD, REG_WARN, 32'hffff_ffff, 1'b1,
			'{1'b0, 32'd0, SEV_CRITICAL, SEV_ERROR, 1'b1, SEV_ERROR, ST_DOWN, 8'h3f}},
		'{ROW_WORD, REG_WARN, 32'd5, 1'b1,
			'{1'b0, 32'd0, SEV_CRITICAL, SEV_CRITICAL, 1'b1, SEV_CRITICAL, ST_DOWN, 8'h1f}},
		// ceiling reached, nothing changes, no event
		'{ROW_WORD, REG_WARN, 32'd7, 1'b1,
			'{1'b0, 32'd0, SEV_CRITICAL, SEV_CRITICAL, 1'b0, SEV_INFO, ST_DOWN, 8'h0f}},
		'{ROW_CFG, REG_WARN,  32'd100, 1'b0, BY_MIRROR},
		'{ROW_CFG, REG_ERROR, 32'd200, 1'b0, BY_MIRROR},
		'{ROW_CFG, REG_CRIT,  32'd300, 1'b0, BY_MIRROR},
		// back up: logs once at the severity held before, then quiet
		'{ROW_WORD, REG_WARN, 32'd50, 1'b1,
			'{1'b1, 32'd100, SEV_INFO, SEV_INFO, 1'b1, SEV_CRITICAL, ST_UP, 8'h87}},
		'{ROW_WORD, REG_WARN, 32'd99, 1'b1,
			'{1'b1, 32'd100, SEV_INFO, SEV_INFO, 1'b0, SEV_INFO, ST_UP, 8'hc3}},
		// rising: escalate one level per word, then drop straight to a lower ceiling
		'{ROW_WORD, REG_WARN, 32'd100, 1'b0, BY_MIRROR},
		'{ROW_WORD, REG_WARN, 32'd250, 1'b0, BY_MIRROR},
		'{ROW_WORD, REG_WARN, 32'd300, 1'b0, BY_MIRROR},
		'{ROW_WORD, REG_WARN, 32'd300, 1'b0, BY_MIRROR},
		'{ROW_WORD, REG_WARN, 32'd150, 1'b0, BY_MIRROR},
		'{ROW_WORD, REG_WARN, 32'hffff_ffff, 1'b0, BY_MIRROR},
		'{ROW_WORD, REG_WARN, 32'd0, 1'b0, BY_MIRROR},
		// critical below warning: automatic turns to falling
		'{ROW_CFG, REG_WARN, 32'd300, 1'b0, BY_MIRROR},
		'{ROW_CFG, REG_CRIT, 32'd100, 1'b0, BY_MIRROR},
		'{ROW_WORD, REG_WARN, 32'd301, 1'b0, BY_MIRROR},
		'{ROW_WORD, REG_WARN, 32'd300, 1'b0, BY_MIRROR},
		'{ROW_WORD, REG_WARN, 32'd0, 1'b0, BY_MIRROR},
		'{ROW_WORD, REG_WARN, 32'd0, 1'b0, BY_MIRROR},
		'{ROW_CFG, REG_DIR, thr_t'(DIR_FALLING), 1'b0, BY_MIRROR},
		'{ROW_WORD, REG_WARN, 32'hffff_ffff, 1'b0, BY_MIRROR},
		// spare code as rising with inverted thresholds: up yet critical ceiling
		'{ROW_CFG, REG_DIR, thr_t'(DIR_SPARE), 1'b0, BY_MIRROR},
		'{ROW_WORD, REG_WARN, 32'd150, 1'b0, BY_MIRROR},
		'{ROW_WORD, REG_WARN, 32'hffff_ffff, 1'b0, BY_MIRROR},
		// all thresholds at the top
		'{ROW_CFG, REG_DIR,   thr_t'(DIR_RISING), 1'b0, BY_MIRROR},
		'{ROW_CFG, REG_WARN,  32'hffff_ffff, 1'b0, BY_MIRROR},
		'{ROW_CFG, REG_ERROR, 32'hffff_ffff, 1'b0, BY_MIRROR},
		'{ROW_CFG, REG_CRIT,  32'hffff_ffff, 1'b0, BY_MIRROR},
		'{ROW_WORD, REG_WARN, 32'hffff_fffe, 1'b0, BY_MIRROR},
		'{ROW_WORD, REG_WARN, 32'hffff_ffff, 1'b0, BY_MIRROR},
		// all thresholds at the bottom, falling
		'{ROW_CFG, REG_DIR,   thr_t'(DIR_FALLING), 1'b0, BY_MIRROR},
		'{ROW_CFG, REG_WARN,  32'd0, 1'b0, BY_MIRROR},
		'{ROW_CFG, REG_ERROR, 32'd0, 1'b0, BY_MIRROR},
		'{ROW_CFG, REG_CRIT,  32'd0, 1'b0, BY_MIRROR},
		'{ROW_WORD, REG_WARN, 32'd0, 1'b0, BY_MIRROR},
		'{ROW_WORD, REG_WARN, 32'd1, 1'b0, BY_MIRROR},
		'{ROW_CFG, REG_DIR, thr_t'(DIR_AUTO), 1'b0, BY_MIRROR}
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = REG_WARN;
	logic [31:0] cfg_wdata = '0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [31:0] sample_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        device_up;
	logic [31:0] crossed_threshold;
	logic [1:0]  max_severity;
	logic [1:0]  current_severity;
	logic        log_now;
	logic [1:0]  log_level;
	logic [1:0]  up_down_state;
	logic [7:0]  history_rating;

	threshold_alarm_severity_tracker i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.sample_value      (sample_value),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.device_up         (device_up),
		.crossed_threshold (crossed_threshold),
		.max_severity      (max_severity),
		.current_severity  (current_severity),
		.log_now           (log_now),
		.log_level         (log_level),
		.up_down_state     (up_down_state),
		.history_rating    (history_rating)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mirror of the tracker: register copy plus the four state registers.
	cfg_t       alarm_cfg;
	sev_t       trk_sev;
	sev_t       trk_logged;
	dev_state_t trk_state;
	hist_t      trk_hist;

	result_t pending_results [$];
	bit      calm = 1'b0;   // phase with no gaps on either side
	int      fail_cnt     = 0;
	int      words_sent   = 0;
	int      results_seen = 0;
	int      phases       = 0;

	function automatic logic past_line(thr_t v, thr_t t, logic rising);
		return rising ? (v >= t) : (v <= t);
	endfunction

	// Classify one sample and advance the mirrored severity state.
	function automatic result_t track_sample(thr_t v);
		result_t r;
		logic    rising;
		sev_t    prev;
		if (alarm_cfg.dir == DIR_AUTO) begin
			rising = alarm_cfg.crit >= alarm_cfg.warn;
		end else begin
			rising = alarm_cfg.dir != DIR_FALLING;
		end
		r.up = !past_line(v, alarm_cfg.warn, rising);
		if (past_line(v, alarm_cfg.crit, rising)) begin
			r.thr = alarm_cfg.crit;
			r.max_sev = SEV_CRITICAL;
		end else if (past_line(v, alarm_cfg.err, rising)) begin
			r.thr = alarm_cfg.err;
			r.max_sev = SEV_ERROR;
		end else begin
			r.thr = alarm_cfg.warn;
			r.max_sev = r.up ? SEV_INFO : SEV_WARNING;
		end
		r.log_now = 1'b0;
		r.log_level = SEV_INFO;
		prev = trk_sev;
		if (r.up) begin
			// coming back up logs at the severity held so far
			if (trk_state != ST_UP) begin
				trk_state = ST_UP;
				r.log_level = trk_sev;
				r.log_now = 1'b1;
				trk_sev = SEV_INFO;
			end
			trk_logged = SEV_INFO;
			trk_hist = {1'b1, trk_hist[HIST_W-1:1]};
		end else begin
			// one step toward a worse ceiling, straight to a better one
			trk_sev = (trk_sev > r.max_sev) ? sev_t'(trk_sev - 2'd1) : r.max_sev;
			if (trk_sev != prev) begin
				trk_state = ST_DOWN;
				trk_logged = (trk_sev < prev) ? trk_sev : prev;
				r.log_level = trk_logged;
				r.log_now = 1'b1;
			end
			trk_hist = {1'b0, trk_hist[HIST_W-1:1]};
		end
		r.cur_sev = trk_sev;
		r.state = trk_state;
		r.hist = trk_hist;
		return r;
	endfunction

	// Entered and left at a falling edge.
	task automatic write_reg(input logic [1:0] idx, input thr_t val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_WARN:  alarm_cfg.warn = val;
			REG_ERROR: alarm_cfg.err = val;
			REG_CRIT:  alarm_cfg.crit = val;
			REG_DIR:   alarm_cfg.dir = val[1:0];
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Drop valid and hold off until every pending result has been checked.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
	endtask

	// Send one sample word; hard = 1 means want is used instead of the mirror.
	task automatic put_word(input thr_t v, input logic hard, input result_t want);
		int      gap;
		result_t r;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample_value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		r = track_sample(v);
		pending_results.push_back(hard ? want : r);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want_v, got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, want_v, got_v);
			fail_cnt++;
		end
	endtask

	// Result side: a fresh stall before each word.
	initial begin : result_sink
		int stall;
		wait (arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing pending");
				fail_cnt++;
			end else begin
				want = pending_results.pop_front();
				results_seen++;
				check_field("device_up", want.up, device_up);
				check_field("crossed_threshold", want.thr, crossed_threshold);
				check_field("max_severity", want.max_sev, max_severity);
				check_field("current_severity", want.cur_sev, current_severity);
				check_field("log_now", want.log_now, log_now);
				check_field("log_level", want.log_level, log_level);
				check_field("up_down_state", want.state, up_down_state);
				check_field("history_rating", want.hist, history_rating);
			end
		end
	end

	initial begin : stimulus
		int   i;
		int   k;
		int   n_dir;
		int   phase_len;
		int   run_len;
		int   pick;
		int   style;
		thr_t anchor;
		thr_t val;
		thr_t w;
		thr_t e;
		thr_t c;
		logic [1:0] dir;

		alarm_cfg = '{warn: '0, err: '0, crit: '0, dir: DIR_AUTO};
		trk_sev = SEV_INFO;
		trk_logged = SEV_INFO;
		trk_state = ST_UNKNOWN;
		trk_hist = HIST_RESET;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed sequence
		for (i = 0; i < N_ROWS; i++) begin
			if (DIR_TAB[i].kind == ROW_CFG) begin
				wait_idle();
				write_reg(DIR_TAB[i].idx, DIR_TAB[i].val);
			end else begin
				put_word(DIR_TAB[i].val, DIR_TAB[i].hard, DIR_TAB[i].want);
			end
		end
		n_dir = words_sent;

		// random phases: new thresholds each phase, then runs of words
		// clustered around one threshold so severity climbs and falls
		while (words_sent - n_dir < N_RAND) begin
			wait_idle();
			phases++;
			calm = ($urandom_range(0, 3) == 0);
			style = $urandom_range(0, 4);
			case (style)
				0: begin
					w = $urandom();
					e = w + $urandom_range(0, 50);
					c = e + $urandom_range(0, 50);
				end
				1: begin
					w = $urandom();
					e = w - $urandom_range(0, 50);
					c = e - $urandom_range(0, 50);
				end
				2: begin
					w = $urandom();
					e = $urandom();
					c = $urandom();
				end
				3: begin
					w = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
					e = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
					c = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
				end
				default: begin
					w = $urandom_range(0, 15);
					e = $urandom_range(0, 15);
					c = $urandom_range(0, 15);
				end
			endcase
			dir = $urandom_range(0, 1) ? DIR_AUTO : 2'($urandom_range(0, 3));
			write_reg(REG_WARN, w);
			write_reg(REG_ERROR, e);
			write_reg(REG_CRIT, c);
			write_reg(REG_DIR, thr_t'(dir));

			phase_len = $urandom_range(30, 70);
			k = 0;
			while (k < phase_len) begin
				pick = $urandom_range(0, 9);
				case (pick)
					0, 1, 2: anchor = alarm_cfg.warn;
					3, 4:    anchor = alarm_cfg.err;
					5, 6:    anchor = alarm_cfg.crit;
					8:       anchor = 32'h0;
					9:       anchor = 32'hffff_ffff;
					default: anchor = '0;
				endcase
				run_len = $urandom_range(1, 5);
				repeat (run_len) begin
					if (pick == 7) begin
						val = $urandom();
					end else begin
						val = anchor + thr_t'($urandom_range(0, 4)) - thr_t'(2);
					end
					put_word(val, 1'b0, BY_MIRROR);
					k++;
				end
			end
		end

		calm = 1'b0;
		wait_idle();
		repeat (8) @(negedge clk);

		$display("Sent %0d sample words: %0d directed, %0d over %0d random threshold sets.",
			words_sent, n_dir, words_sent - n_dir, phases);
		$display("Checked %0d result words against the tracker mirror.", results_seen);
		if (fail_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Hard stop, far past the slowest legal run.
	initial begin : watchdog
		#400000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
